### rtl/sml_pkg.sv
package sml_pkg;

  // Pattern window depth and text position counter width
  localparam int unsigned MAX_PATTERN   = 8;
  localparam int unsigned POSITION_BITS = 16;

  // Fixed field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PAT_W     = 64;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned OUT_POS_W = 16;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Derived widths
  localparam int unsigned FILL_W    = $clog2(MAX_PATTERN + 1);
  localparam int unsigned WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned BLOCK_W   = POSITION_BITS + 1;

  // Dropped byte value and saturation limits
  localparam logic [BYTE_W-1:0]        DROP_BYTE = 8'hC3;
  localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
  localparam logic [COUNT_W-1:0]       HITS_MAX  = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;

  typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_t;

endpackage

### rtl/substring_match_locator_top.sv
// Streaming substring locator. Text arrives one byte per input beat; every
// 0xC3 byte is dropped and the kept bytes are numbered from 1. A window of the
// most recent kept bytes is compared in parallel against the configured
// pattern (up to MAX_PATTERN bytes, first byte in the lowest octet, length 0
// disables matching, lengths above MAX_PATTERN act as MAX_PATTERN). Each match
// produces one result beat with its start and end positions; a match starting
// one position after the previous reported start is suppressed. The beat that
// carries last_byte always produces a result carrying the total match count,
// and then clears the per-text state. Throughput is one input beat per clock:
// a beat accepted into the input register passes one level of window compare
// logic and lands in the result register when it moves on. A beat that
// produces no result moves on even while a finished result waits on a
// stalled output; a result-bearing beat holds in the input register,
// stalling the input, until the waiting result is taken. Write
// configuration only while no beat is in flight.
module substring_match_locator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port
  input  logic                         cfg_we_i,
  input  logic [sml_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sml_pkg::PAT_W-1:0]    cfg_data_i,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sml_pkg::BYTE_W-1:0]   text_byte_i,
  input  logic                         last_byte_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         match_found_o,
  output logic [sml_pkg::OUT_POS_W-1:0] match_start_o,
  output logic [sml_pkg::OUT_POS_W-1:0] match_end_o,
  output logic                         end_of_text_o,
  output logic [sml_pkg::COUNT_W-1:0]  match_count_o
);
  import sml_pkg::*;

  // Configuration registers
  logic [PAT_W-1:0] pattern_bytes_q;
  logic [LEN_W-1:0] pattern_length_q;

  // Input stage
  logic              s1_valid_q;
  logic [BYTE_W-1:0] s1_byte_q;
  logic              s1_last_q;

  // Per-text state
  window_t                window_q, window_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [POSITION_BITS-1:0] kept_q, kept_d;
  logic [BLOCK_W-1:0]     blocked_q, blocked_d;
  logic [COUNT_W-1:0]     hits_q, hits_d;

  // Result register
  logic                 out_valid_q;
  logic                 found_q;
  logic [OUT_POS_W-1:0] start_q;
  logic [OUT_POS_W-1:0] end_q;
  logic                 eot_q;
  logic [COUNT_W-1:0]   count_q;

  logic                     kept_byte;
  logic [LEN_W-1:0]         len_act;
  window_t                  win_new;
  logic [FILL_W-1:0]        fill_new;
  logic [POSITION_BITS-1:0] kept_new;
  logic                     win_match;
  logic [POSITION_BITS-1:0] match_pos;
  logic                     found;
  logic [COUNT_W-1:0]       hits_new;
  logic                     has_result;
  logic                     out_free;
  logic                     s1_fire;
  logic                     in_fire;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_bytes_q  <= '0;
      pattern_length_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_PATTERN_BYTES) begin
        pattern_bytes_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_PATTERN_LENGTH) begin
        pattern_length_q <= cfg_data_i[LEN_W-1:0];
      end
    end
  end

  // Window compare for the beat held in the input stage
  always_comb begin
    kept_byte = (s1_byte_q != DROP_BYTE);
    len_act   = (pattern_length_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                         : pattern_length_q;
    win_new   = {window_q[MAX_PATTERN-2:0], s1_byte_q};
    fill_new  = (fill_q < FILL_W'(MAX_PATTERN)) ? fill_q + FILL_W'(1) : fill_q;
    kept_new  = (kept_q < POS_MAX) ? kept_q + POSITION_BITS'(1) : kept_q;

    win_match = (len_act != '0) && (LEN_W'(fill_new) >= len_act) &&
                (kept_new >= POSITION_BITS'(len_act));
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (LEN_W'(k) < len_act) begin
        if (win_new[WIN_IDX_W'(len_act - LEN_W'(1) - LEN_W'(k))] !=
            pattern_bytes_q[BYTE_W*k +: BYTE_W]) begin
          win_match = 1'b0;
        end
      end
    end

    match_pos  = kept_new - POSITION_BITS'(len_act) + POSITION_BITS'(1);
    found      = kept_byte && win_match && ({1'b0, match_pos} != blocked_q);
    hits_new   = (found && hits_q < HITS_MAX) ? hits_q + COUNT_W'(1) : hits_q;
    has_result = found || s1_last_q;
  end

  // Handshake: the input stage advances unless its result must wait on a
  // stalled, occupied result register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!has_result || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Next per-text state: advance on kept bytes, clear after the last beat
  always_comb begin
    window_d  = window_q;
    fill_d    = fill_q;
    kept_d    = kept_q;
    blocked_d = blocked_q;
    hits_d    = hits_q;
    if (s1_last_q) begin
      window_d  = '0;
      fill_d    = '0;
      kept_d    = '0;
      blocked_d = '0;
      hits_d    = '0;
    end else if (kept_byte) begin
      window_d = win_new;
      fill_d   = fill_new;
      kept_d   = kept_new;
      hits_d   = hits_new;
      if (found) begin
        blocked_d = {1'b0, match_pos} + BLOCK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= '0;
      fill_q    <= '0;
      kept_q    <= '0;
      blocked_q <= '0;
      hits_q    <= '0;
    end else if (s1_fire) begin
      window_q  <= window_d;
      fill_q    <= fill_d;
      kept_q    <= kept_d;
      blocked_q <= blocked_d;
      hits_q    <= hits_d;
    end
  end

  // Input register: take a new beat whenever the held one moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= text_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // Result register: load on a result-bearing beat, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && has_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && has_result) begin
      found_q <= found;
      start_q <= found ? OUT_POS_W'(match_pos) : '0;
      end_q   <= found ? OUT_POS_W'(kept_new) : '0;
      eot_q   <= s1_last_q;
      count_q <= kept_byte ? hits_new : hits_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign match_found_o = found_q;
  assign match_start_o = start_q;
  assign match_end_o   = end_q;
  assign end_of_text_o = eot_q;
  assign match_count_o = count_q;

`ifndef ASSERT_OFF
  // A reported match never spans more than the window
  a_match_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && match_found_o |->
      (OUT_POS_W'(match_end_o - match_start_o) < OUT_POS_W'(MAX_PATTERN)))
    else $error("match span exceeds window depth");

  // A result without a match carries zero positions
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !match_found_o |-> (match_start_o == '0) && (match_end_o == '0))
    else $error("non-match result carries positions");

  // Upstream stall only arises from an occupied, blocked input stage
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");
`endif

endmodule
